@@ rtl/core/pdq_pkg.sv @@
// pdq_pkg: shared types and constants for the pcm down-mix q15 decimator
// holds the controller state encoding, the command/status structs and the register map
// no dependencies
package pdq_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_RATE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_RATE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_SAMPLES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_Q_BITS        = 3'd4;

    localparam logic [15:0] RST_OUTPUT_RATE = 16'd16000;
    localparam logic [17:0] RST_INPUT_RATE  = 18'd16000;
    localparam logic [1:0]  RST_CHANNELS    = 2'd1;

    localparam logic [15:0] MIN_OUTPUT_RATE = 16'd8000;
    localparam logic [17:0] MAX_INPUT_RATE  = 18'd192000;
    localparam logic [4:0]  MAX_Q_BITS      = 5'd30;
    localparam logic [4:0]  Q_DEFAULT_WIDE  = 5'd23;
    localparam logic [4:0]  Q_DEFAULT_NARROW = 5'd15;
    localparam logic [4:0]  Q_TARGET        = 5'd15;

    localparam logic signed [47:0] Q15_MAX = 48'sd32767;
    localparam logic signed [47:0] Q15_MIN = -48'sd32768;

    // magnitude of the boxcar sum, one quotient bit per divide step
    localparam int unsigned DIV_W = 20;
    localparam int unsigned CNT_W = 5;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MIX   = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;      // capture the frame
        logic mix;       // down-mix to mono
        logic scale;     // rescale, accumulate, advance phase
        logic div_step;  // one restoring divide step
        logic out_load;  // move quotient into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic format_ok;
        logic emit;      // last scale step crossed the input rate
        logic out_busy;  // output register holds a beat not taken this cycle
    } dp_status_t;

endpackage

@@ rtl/core/pdq_ctrl.sv @@
// pdq_ctrl: sequencer for the pcm down-mix q15 decimator
// steps each frame through mix and scale, then through divide and output when it emits; uses pdq_pkg
module pdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pdq_pkg::dp_status_t status,
    output pdq_pkg::dp_cmd_t    cmd
);
    import pdq_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  step_reg, step_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // frames of an unsupported format are taken and dropped
                if (in_valid && status.format_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.emit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    step_next    = step_reg + CNT_W'(1);
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ rtl/core/pdq_datapath.sv @@
// pdq_datapath: registers, mixer, q15 rescaler, phase accumulator and serial divider
// driven by pdq_ctrl commands; uses pdq_pkg
module pdq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pdq_pkg::dp_cmd_t                    cmd,
    output pdq_pkg::dp_status_t                 status,
    input  logic                                cfg_write,
    input  logic [pdq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pdq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [31:0]                         first_sample,
    input  logic [31:0]                         second_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [15:0]                         out_sample
);
    import pdq_pkg::*;

    // configuration
    logic [15:0] output_rate_reg;
    logic [17:0] input_rate_reg;
    logic [1:0]  channel_count_reg;
    logic        wide_samples_reg;
    logic [4:0]  q_bits_reg;

    // accumulator state
    logic [17:0]        phase_acc_reg, phase_acc_next;
    logic signed [20:0] avg_sum_reg, avg_sum_next;
    logic [CNT_W-1:0]   avg_count_reg, avg_count_next;
    logic               emit_reg;

    // payload
    logic [31:0]        first_reg, second_reg;
    logic signed [32:0] mono_reg;
    logic [DIV_W-1:0]   quot_reg;
    logic [CNT_W:0]     rem_reg;
    logic [CNT_W-1:0]   den_reg;
    logic               neg_reg;
    logic [15:0]        out_data_reg;
    logic               out_valid_reg;

    logic cfg_hit;
    assign cfg_hit = cfg_write && (cfg_index <= REG_Q_BITS);

    assign status.format_ok = ({2'b00, output_rate_reg} >= {2'b00, MIN_OUTPUT_RATE})
                           && (input_rate_reg >= {2'b00, output_rate_reg})
                           && (input_rate_reg <= MAX_INPUT_RATE)
                           && (channel_count_reg == 2'd1 || channel_count_reg == 2'd2)
                           && (q_bits_reg <= MAX_Q_BITS);
    assign status.emit     = emit_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    // down-mix, halving truncates toward zero
    logic signed [32:0] samp_a, samp_b, mono_next;
    logic signed [33:0] pair_sum, pair_adj;
    always_comb
    begin
        if (wide_samples_reg)
        begin
            samp_a = {first_reg[31], first_reg};
            samp_b = {second_reg[31], second_reg};
        end
        else
        begin
            samp_a = {{17{first_reg[15]}}, first_reg[15:0]};
            samp_b = {{17{second_reg[15]}}, second_reg[15:0]};
        end
        pair_sum = {samp_a[32], samp_a} + {samp_b[32], samp_b};
        pair_adj = pair_sum + {33'd0, pair_sum[33]};
        if (channel_count_reg == 2'd2)
        begin
            mono_next = pair_adj[33:1];
        end
        else
        begin
            mono_next = samp_a;
        end
    end

    // rescale to q15 with floor on right shifts, then saturate
    logic [4:0]         q_eff;
    logic signed [47:0] mono_ext, shifted;
    logic signed [15:0] q15;
    logic [18:0]        phase_sum;
    logic [DIV_W:0]     sum_mag;
    always_comb
    begin
        if (q_bits_reg == 5'd0)
        begin
            q_eff = wide_samples_reg ? Q_DEFAULT_WIDE : Q_DEFAULT_NARROW;
        end
        else
        begin
            q_eff = q_bits_reg;
        end
        mono_ext = {{15{mono_reg[32]}}, mono_reg};
        if (q_eff >= Q_TARGET)
        begin
            shifted = mono_ext >>> (q_eff - Q_TARGET);
        end
        else
        begin
            shifted = mono_ext <<< (Q_TARGET - q_eff);
        end
        if (shifted > Q15_MAX)
        begin
            q15 = 16'sh7fff;
        end
        else if (shifted < Q15_MIN)
        begin
            q15 = 16'sh8000;
        end
        else
        begin
            q15 = shifted[15:0];
        end
        avg_sum_next   = avg_sum_reg + {{5{q15[15]}}, q15};
        avg_count_next = avg_count_reg + CNT_W'(1);
        phase_sum      = {1'b0, phase_acc_reg} + {3'd0, output_rate_reg};
        phase_acc_next = phase_sum[17:0];
        sum_mag        = avg_sum_next[20] ? -avg_sum_next : avg_sum_next;
    end

    // restoring divide step
    logic [CNT_W:0] rem_shift, rem_sub;
    assign rem_shift = {rem_reg[CNT_W-1:0], quot_reg[DIV_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    logic [15:0] quot_signed;
    assign quot_signed = neg_reg ? (~quot_reg[15:0] + 16'd1) : quot_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_rate_reg   <= RST_OUTPUT_RATE;
            input_rate_reg    <= RST_INPUT_RATE;
            channel_count_reg <= RST_CHANNELS;
            wide_samples_reg  <= 1'b0;
            q_bits_reg        <= '0;
            phase_acc_reg     <= '0;
            avg_sum_reg       <= '0;
            avg_count_reg     <= '0;
            emit_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_OUTPUT_RATE:   output_rate_reg   <= cfg_data[15:0];
                    REG_INPUT_RATE:    input_rate_reg    <= cfg_data;
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[1:0];
                    REG_WIDE_SAMPLES:  wide_samples_reg  <= cfg_data[0];
                    REG_Q_BITS:        q_bits_reg        <= cfg_data[4:0];
                    default:           ;
                endcase
            end
            if (cfg_hit)
            begin
                phase_acc_reg <= '0;
                avg_sum_reg   <= '0;
                avg_count_reg <= '0;
            end
            else if (cmd.scale)
            begin
                if ({1'b0, input_rate_reg} <= phase_sum)
                begin
                    phase_acc_reg <= phase_acc_next - input_rate_reg;
                    avg_sum_reg   <= '0;
                    avg_count_reg <= '0;
                end
                else
                begin
                    phase_acc_reg <= phase_acc_next;
                    avg_sum_reg   <= avg_sum_next;
                    avg_count_reg <= avg_count_next;
                end
            end
            if (cmd.scale)
            begin
                emit_reg <= ({1'b0, input_rate_reg} <= phase_sum);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg  <= first_sample;
            second_reg <= second_sample;
        end
        if (cmd.mix)
        begin
            mono_reg <= mono_next;
        end
        if (cmd.scale)
        begin
            quot_reg <= sum_mag[DIV_W-1:0];
            neg_reg  <= avg_sum_next[20];
            den_reg  <= avg_count_next;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[CNT_W])
            begin
                rem_reg  <= rem_sub;
                quot_reg <= {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                quot_reg <= {quot_reg[DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= quot_signed;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_data_reg;

endmodule

@@ rtl/core/pcm_downmix_q15_decimator.sv @@
// pcm_downmix_q15_decimator: top level of the mono down-mix, q15 rescale and boxcar decimator
// joins pdq_ctrl and pdq_datapath; uses pdq_pkg
//
// One frame per input beat: it is mixed to mono, rescaled to q15 and summed into a
// boxcar, and a phase accumulator adding output_rate against input_rate picks the
// frames that close a boxcar and give one averaged output beat. A frame that closes
// no boxcar passes through capture, mix, scale and one pass through the divide state
// back to idle; a frame that emits also runs the 20-step restoring divide that forms
// the average. Frames in an unsupported format are taken and dropped. The output
// register lets the next frame enter while a result still waits on m_tready.
// Writing any listed register clears the phase and the boxcar; writes are meant only
// while the block is idle, and cfg_ready is always high.
module pcm_downmix_q15_decimator (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pdq_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input frames
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // first_sample[31:0], second_sample[63:32]
    input  logic                            s_tlast,   // last_in_packet
    // output samples
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata    // out_sample[15:0]
);
    import pdq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       frame_last_reg;

    assign cfg_ready = 1'b1;

    pdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .first_sample  (s_tdata[31:0]),
        .second_sample (s_tdata[63:32]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_sample    (m_tdata)
    );

    // packet end mark has no effect on the arithmetic; kept with the captured frame
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_last_reg <= s_tlast;
        end
    end

endmodule

@@ tb/pcm_downmix_q15_decimator_tb.sv @@
`timescale 1ns / 100ps
// pcm_downmix_q15_decimator_tb: self-checking bench for the mono down-mix q15 decimator
// drives frame beats and register writes, predicts every averaged sample and checks the output
// depends on pdq_pkg and pcm_downmix_q15_decimator
module pcm_downmix_q15_decimator_tb;
    import pdq_pkg::*;

    localparam int unsigned RANDOM_FRAMES   = 1650;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned RX_HOLD_CYCLES  = 400;
    localparam int unsigned NOMINAL_MAX_OUT = 48000;
    localparam int unsigned MAX_OUT_REG     = 65535;
    localparam int unsigned SPARE_INDEXES   = (1 << CFG_INDEX_W) - 1 - REG_Q_BITS;
    localparam int unsigned MAX_PRINTED     = 100;

    typedef enum int unsigned {
        BAD_SLOW_OUT,
        BAD_IN_BELOW_OUT,
        BAD_IN_TOO_FAST,
        BAD_NO_CHANNEL,
        BAD_THREE_CHANNELS,
        BAD_Q31
    } bad_format_t;

    class mono_q15_predictor;
        logic [15:0] out_rate;
        logic [17:0] in_rate;
        logic [1:0]  chans;
        logic        wide;
        logic [4:0]  q_fmt;
        int unsigned phase;
        int          boxcar_sum;
        int          boxcar_len;
        logic [15:0] pending_samples[$];
        int unsigned errors;

        function new();
            out_rate = RST_OUTPUT_RATE;
            in_rate  = RST_INPUT_RATE;
            chans    = RST_CHANNELS;
            wide     = 1'b0;
            q_fmt    = '0;
            errors   = 0;
            clear_boxcar();
        endfunction

        function void clear_boxcar();
            phase      = 0;
            boxcar_sum = 0;
            boxcar_len = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_OUTPUT_RATE:   out_rate = data[15:0];
                REG_INPUT_RATE:    in_rate = data[17:0];
                REG_CHANNEL_COUNT: chans = data[1:0];
                REG_WIDE_SAMPLES:  wide = data[0];
                REG_Q_BITS:        q_fmt = data[4:0];
                default:           return;
            endcase
            clear_boxcar();
        endfunction

        function logic [CFG_DATA_W-1:0] reg_value(logic [CFG_INDEX_W-1:0] idx);
            case (idx)
                REG_OUTPUT_RATE:   return CFG_DATA_W'(out_rate);
                REG_INPUT_RATE:    return CFG_DATA_W'(in_rate);
                REG_CHANNEL_COUNT: return CFG_DATA_W'(chans);
                REG_WIDE_SAMPLES:  return CFG_DATA_W'(wide);
                REG_Q_BITS:        return CFG_DATA_W'(q_fmt);
                default:           return '0;
            endcase
        endfunction

        function bit format_ok();
            return out_rate >= MIN_OUTPUT_RATE && in_rate >= out_rate
                && in_rate <= MAX_INPUT_RATE && chans >= 2'd1 && chans <= 2'd2
                && q_fmt <= MAX_Q_BITS;
        endfunction

        function int unsigned q_eff();
            if (q_fmt != '0)
                return 32'(q_fmt);
            return wide ? 32'(Q_DEFAULT_WIDE) : 32'(Q_DEFAULT_NARROW);
        endfunction

        function longint sample_of(logic [31:0] raw);
            logic signed [15:0] narrow;
            logic signed [31:0] full;
            narrow = raw[15:0];
            full   = raw;
            return wide ? longint'(full) : longint'(narrow);
        endfunction

        function void take_frame(logic [31:0] first, logic [31:0] second);
            longint      mono;
            int unsigned qe;
            int          q15;
            int unsigned nxt;
            if (!format_ok())
                return;
            mono = sample_of(first);
            if (chans == 2'd2)
                mono = (mono + sample_of(second)) / 2;
            qe = q_eff();
            // arithmetic shift floors negative values
            if (qe > Q_TARGET)
                mono = mono >>> (qe - Q_TARGET);
            else if (qe < Q_TARGET)
                mono = mono <<< (Q_TARGET - qe);
            if (mono > Q15_MAX)
                q15 = int'(Q15_MAX);
            else if (mono < Q15_MIN)
                q15 = int'(Q15_MIN);
            else
                q15 = int'(mono);
            boxcar_sum += q15;
            boxcar_len++;
            nxt = phase + out_rate;
            if (nxt >= in_rate) begin
                pending_samples.push_back(16'(boxcar_sum / boxcar_len));
                phase      = nxt - in_rate;
                boxcar_sum = 0;
                boxcar_len = 0;
            end
            else begin
                phase = nxt;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t ns: %s", $time, msg);
        endtask

        task check_sample(logic [15:0] got);
            logic [15:0] want;
            if (pending_samples.size() == 0) begin
                report($sformatf("out_sample %0d with nothing expected", $signed(got)));
                return;
            end
            want = pending_samples.pop_front();
            if (got !== want)
                report($sformatf("out_sample got %0d, expected %0d", $signed(got), $signed(want)));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;   // first_sample[31:0], second_sample[63:32]
    logic                   s_tlast;   // last_in_packet
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;   // out_sample[15:0]

    mono_q15_predictor mono_ref;
    int unsigned       tx_idle_pct;
    int unsigned       rx_idle_pct;
    bit                rx_hold_req  = 1'b0;
    int unsigned       rx_hold_left = 0;
    int unsigned       frames_counted;

    pcm_downmix_q15_decimator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mono_ref.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // junk above the register width must be dropped
    task automatic write_field(logic [CFG_INDEX_W-1:0] idx, int unsigned value,
                               int unsigned width);
        write_reg(idx, CFG_DATA_W'(($urandom << width) | value));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (mono_ref.pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_format(int unsigned out_r, int unsigned in_r, int unsigned ch,
                                int unsigned wd, int unsigned q);
        settle();
        write_field(REG_OUTPUT_RATE, out_r, 16);
        write_field(REG_INPUT_RATE, in_r, CFG_DATA_W);
        write_field(REG_CHANNEL_COUNT, ch, 2);
        write_field(REG_WIDE_SAMPLES, wd, 1);
        write_field(REG_Q_BITS, q, 5);
    endtask

    task automatic apply_random_format(bit broken, bad_format_t kind);
        int unsigned out_r;
        int unsigned in_r;
        int unsigned ch;
        int unsigned wd;
        int unsigned q;
        case ($urandom_range(0, 5))
            0:       out_r = 32'(MIN_OUTPUT_RATE);
            1:       out_r = NOMINAL_MAX_OUT;
            2:       out_r = $urandom_range(NOMINAL_MAX_OUT + 1, MAX_OUT_REG);
            default: out_r = $urandom_range(MIN_OUTPUT_RATE, NOMINAL_MAX_OUT);
        endcase
        case ($urandom_range(0, 5))
            0:       in_r = out_r;
            1:       in_r = 32'(MAX_INPUT_RATE);
            2:       in_r = out_r * 2;
            3:       in_r = (out_r * 3 > MAX_INPUT_RATE) ? 32'(MAX_INPUT_RATE) : out_r * 3;
            default: in_r = $urandom_range(out_r, MAX_INPUT_RATE);
        endcase
        ch = $urandom_range(1, 2);
        wd = $urandom_range(0, 1);
        case ($urandom_range(0, 7))
            0:       q = 0;
            1:       q = 32'(MAX_Q_BITS);
            2:       q = 1;
            3:       q = 32'(Q_TARGET);
            default: q = $urandom_range(0, MAX_Q_BITS);
        endcase
        if (broken) begin
            case (kind)
                BAD_SLOW_OUT:
                    out_r = $urandom_range(0, MIN_OUTPUT_RATE - 1);
                BAD_IN_BELOW_OUT:
                begin
                    out_r = $urandom_range(MIN_OUTPUT_RATE + 1, MAX_OUT_REG);
                    in_r  = $urandom_range(0, out_r - 1);
                end
                BAD_IN_TOO_FAST:
                    in_r = $urandom_range(MAX_INPUT_RATE + 1, (1 << CFG_DATA_W) - 1);
                BAD_NO_CHANNEL:
                    ch = 0;
                BAD_THREE_CHANNELS:
                    ch = 3;
                default:
                    q = 32'(MAX_Q_BITS) + 1;
            endcase
        end
        apply_format(out_r, in_r, ch, wd, q);
    endtask

    // registers only change while the block is idle
    task automatic mid_phase_write();
        logic [CFG_INDEX_W-1:0] idx;
        settle();
        if ($urandom_range(0, 1) == 0) begin
            // spare indexes leave the boxcar alone
            idx = REG_Q_BITS + CFG_INDEX_W'($urandom_range(1, SPARE_INDEXES));
            write_reg(idx, CFG_DATA_W'($urandom));
        end
        else begin
            idx = CFG_INDEX_W'($urandom_range(REG_OUTPUT_RATE, REG_Q_BITS));
            write_reg(idx, mono_ref.reg_value(idx));
        end
    endtask

    task automatic send_frame(logic [31:0] first, logic [31:0] second);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {second, first};
        s_tlast  <= 1'($urandom_range(0, 1));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        mono_ref.take_frame(first, second);
    endtask

    function automatic logic [31:0] pick_sample();
        int unsigned qe;
        int unsigned w;
        int unsigned bits;
        logic [31:0] v;
        qe = mono_ref.q_eff();
        w  = mono_ref.wide ? 32 : 16;
        case ($urandom_range(0, 9))
            0, 1:
                v = $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = '0;
                    default: v = '1;
                endcase
                v[15:0] = v[31:16];
            end
            default:
            begin
                // around full scale of the active q format
                bits = (qe + 1 < w) ? qe + 1 : w;
                v = $urandom;
                v = $signed(v << (32 - bits)) >>> (32 - bits);
            end
        endcase
        if (!mono_ref.wide)
            v[31:16] = 16'($urandom);
        return v;
    endfunction

    initial
    begin : rx_side
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin : out_monitor
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                mono_ref.check_sample(m_tdata);
        end
    end

    initial
    begin : watchdog
        #(12_000_000);
        $display("pcm_downmix_q15_decimator_tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned n;
        int unsigned split;
        int unsigned i;
        int unsigned k;
        bit          broken;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        tx_idle_pct    = 12;
        rx_idle_pct    = 77;
        frames_counted = 0;
        mono_ref       = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // reset format: narrow mono q15, every frame closes a boxcar
        send_frame(32'hA5A5_7FFF, $urandom);
        send_frame(32'h5A5A_8000, $urandom);
        send_frame(32'h0000_0000, $urandom);
        send_frame(32'hFFFF_FFFF, $urandom);
        send_frame($urandom, $urandom);

        // wide stereo at default q23, full-scale pairs and mix truncation toward zero
        apply_format(NOMINAL_MAX_OUT, NOMINAL_MAX_OUT, 2, 1, 0);
        send_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_frame(32'h8000_0000, 32'h8000_0000);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000);
        send_frame(32'hFFFF_FFFF, 32'h0000_0000);

        // deepest right shift, floors toward minus infinity
        apply_format(32'(MIN_OUTPUT_RATE), 32'(MIN_OUTPUT_RATE), 1, 1, 32'(MAX_Q_BITS));
        send_frame(32'h8000_0000, $urandom);
        send_frame(32'h7FFF_FFFF, $urandom);
        send_frame(32'hFFFF_FFFF, $urandom);

        // narrow q1, left shift into saturation
        apply_format(32'(MIN_OUTPUT_RATE), 32'(MIN_OUTPUT_RATE), 1, 0, 1);
        send_frame(32'hC3C3_0001, $urandom);
        send_frame(32'h3C3C_0002, $urandom);
        send_frame(32'h0000_FFFE, $urandom);

        // three frames per output, average truncated toward zero
        apply_format(32'(MIN_OUTPUT_RATE), 3 * 32'(MIN_OUTPUT_RATE), 2, 0,
                     32'(Q_DEFAULT_NARROW));
        send_frame(32'h0000_7FFF, 32'h0000_7FFF);
        send_frame(32'h0000_7FFF, 32'h0000_8000);
        send_frame(32'h0000_8000, 32'h0000_8000);

        // every unsupported format drops its frame
        for (k = BAD_SLOW_OUT; k <= BAD_Q31; k++) begin
            apply_random_format(1'b1, bad_format_t'(k));
            send_frame($urandom, $urandom);
        end

        // receiver stalls while every frame emits, so the block backs up into s_tready
        apply_format(32'(RST_OUTPUT_RATE), 32'(RST_OUTPUT_RATE), 2, 1, 0);
        rx_hold_req = 1'b1;
        repeat (24) begin
            send_frame(pick_sample(), pick_sample());
            frames_counted++;
        end

        while (frames_counted < RANDOM_FRAMES) begin
            if (frames_counted >= 2 * RANDOM_FRAMES / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (frames_counted >= RANDOM_FRAMES / 3) begin
                tx_idle_pct = 77;
                rx_idle_pct = 12;
            end
            broken = ($urandom_range(0, 9) == 0);
            apply_random_format(broken, bad_format_t'($urandom_range(BAD_SLOW_OUT, BAD_Q31)));
            n     = broken ? 8 : $urandom_range(15, 60);
            split = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : n;
            for (i = 0; i < n; i++) begin
                if (i == split)
                    mid_phase_write();
                send_frame(pick_sample(), pick_sample());
                if (!broken)
                    frames_counted++;
            end
        end

        settle();
        if (mono_ref.errors == 0)
            $display("pcm_downmix_q15_decimator_tb: clean");
        else
            $display("pcm_downmix_q15_decimator_tb: errors");
        $finish;
    end

endmodule
